// ===== hw/rtl/stereo_ping_pong_delay_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Stereo ping-pong delay assertion macros
// Shared forms for the concurrent checks of the delay unit.
// ----------------------------------------------------------------------------
`ifndef STEREO_PING_PONG_DELAY_UNIT_MACROS_SVH
`define STEREO_PING_PONG_DELAY_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SPPD_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SPPD_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/sppd_pkg.sv =====
// ----------------------------------------------------------------------------
// Stereo ping-pong delay package
// Register codes, reset values, limits and shared control types.
// ----------------------------------------------------------------------------
`default_nettype none

package sppd_pkg;

  // Width of every Q1.15 factor fed to the serial multipliers.
  localparam int FACTOR_BITS = 16;
  // Two multiplier bits are consumed per cycle.
  localparam int DIGIT_STEPS = FACTOR_BITS / 2;
  localparam int STEP_BITS   = $clog2(DIGIT_STEPS);

  // Configuration port.
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;

  localparam int DELAY_BITS = 15;
  localparam int GAIN_BITS  = 15;
  localparam int WIDTH_BITS = 16;
  localparam int MIX_BITS   = 16;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_DELAY = 3'd0,
    REG_GAIN  = 3'd1,
    REG_WIDTH = 3'd2,
    REG_MIX   = 3'd3
  } cfg_reg_t;

  localparam logic [DELAY_BITS-1:0] DELAY_RESET = 15'd12000;
  localparam logic [GAIN_BITS-1:0]  GAIN_RESET  = 15'd16384;
  localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = 16'd32768;
  localparam logic [MIX_BITS-1:0]   MIX_RESET   = 16'd16384;

  // Feedback is limited to 0.95; width and mix to one.
  localparam logic [GAIN_BITS-1:0]   FB_LIMIT = 15'd31130;
  localparam logic [FACTOR_BITS-1:0] UNITY    = 16'd32768;

  // Control of one serial multiply lane.
  typedef struct packed {
    logic load;
    logic step;
  } mac_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sppd_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sppd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with output register.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sppd_mac.sv =====
// ----------------------------------------------------------------------------
// Serial multiply lane
// Computes base + round(mcand * mplier / 2^15), two multiplier bits a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sppd_mac #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  sppd_pkg::mac_ctrl_t                 ctrl,
  input  logic signed [SAMPLE_BITS:0]         mcand,
  input  logic [sppd_pkg::FACTOR_BITS-1:0]    mplier,
  input  logic signed [SAMPLE_BITS:0]         base,
  output logic signed [SAMPLE_BITS+1:0]       result
);

  import sppd_pkg::*;

  localparam int AW = SAMPLE_BITS + 3;

  logic signed [SAMPLE_BITS:0] mcand_r;
  logic signed [SAMPLE_BITS:0] base_r;
  logic [FACTOR_BITS-1:0]      mplier_r;
  logic signed [AW-1:0]        acc_r;
  logic [FACTOR_BITS-1:0]      low_r;

  logic signed [AW-1:0]        mcand_ext;
  logic signed [AW-1:0]        part;
  logic signed [AW-1:0]        sum;
  logic signed [AW+1:0]        rounded;
  logic signed [AW+1:0]        total;

  // Partial product of one two-bit digit, added to the running high part.
  always_comb begin
    mcand_ext = AW'(mcand_r);
    part      = '0;
    if (mplier_r[0]) begin
      part = part + mcand_ext;
    end
    if (mplier_r[1]) begin
      part = part + (mcand_ext <<< 1);
    end
    sum = acc_r + part;
  end

  // Low product bits leave the accumulator into a shift register.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      mcand_r  <= mcand;
      base_r   <= base;
      mplier_r <= mplier;
      acc_r    <= '0;
      low_r    <= '0;
    end else if (ctrl.step) begin
      mplier_r <= mplier_r >> 2;
      acc_r    <= sum >>> 2;
      low_r    <= {sum[1:0], low_r[FACTOR_BITS-1:2]};
    end
  end

  // Round half up at bit 15: the top low bit joins the result, the next one
  // is the rounding carry.
  always_comb begin
    rounded = (AW+2)'($signed({acc_r, low_r[FACTOR_BITS-1]}))
            + (AW+2)'($signed({1'b0, low_r[FACTOR_BITS-2]}));
    total   = (AW+2)'(base_r) + rounded;
    result  = total[SAMPLE_BITS+1:0];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/stereo_ping_pong_delay_unit.sv =====
// ----------------------------------------------------------------------------
// Stereo ping-pong delay unit
// Two delay lines with cross feedback and a dry/wet crossfade per channel.
//
// Input channel in_valid/in_ready carries one stereo pair per transfer;
// output channel out_valid/out_ready returns one mixed pair per input.
// The cfg channel writes delay_samples, feedback_gain, cross_width and
// wet_mix by index; cfg_ready is always high. Writes are to be made while
// idle; the block itself does not enforce this. An item passes a memory
// read and lane load, two-bit serial multiplies for the feedback and output
// fades, a load of the gain, serial multiplies for the gain, and a write
// that also fills the output register. The next item can be taken in the
// cycle after the write, so the block works on one pair at a time.
// Reset clears the write pointer, restores the register defaults and marks
// the delay lines empty: until the pointer first wraps, entries not yet
// written read as zero, so no clearing pass is needed.
// If the receiver stalls, the finished pair waits in the output register
// while the next item is processed; that item then holds in its write
// cycle until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_ping_pong_delay_unit #(
  parameter int LINE_DEPTH  = 32768,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [SAMPLE_BITS-1:0]        in_left,
  input  logic signed [SAMPLE_BITS-1:0]        in_right,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [SAMPLE_BITS-1:0]        out_left,
  output logic signed [SAMPLE_BITS-1:0]        out_right,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [sppd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [sppd_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  import sppd_pkg::*;

  localparam int PTR_BITS = $clog2(LINE_DEPTH);
  localparam int DW       = (PTR_BITS > DELAY_BITS) ? PTR_BITS : DELAY_BITS;
  localparam logic [DW-1:0]       D_MAX = DW'(LINE_DEPTH - 1);
  localparam logic [PTR_BITS-1:0] P_LAST = PTR_BITS'(LINE_DEPTH - 1);
  localparam logic signed [SAMPLE_BITS+1:0] S_MAX =
    {3'b000, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS+1:0] S_MIN =
    {3'b111, {(SAMPLE_BITS-1){1'b0}}};

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_LOAD   = 6'b000010,
    ST_MUL_A  = 6'b000100,
    ST_LOAD_B = 6'b001000,
    ST_MUL_B  = 6'b010000,
    ST_WRITE  = 6'b100000
  } state_t;

  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
    input logic signed [SAMPLE_BITS+1:0] v
  );
    logic signed [SAMPLE_BITS+1:0] c;
    c = v;
    if (v > S_MAX) begin
      c = S_MAX;
    end else if (v < S_MIN) begin
      c = S_MIN;
    end
    return c[SAMPLE_BITS-1:0];
  endfunction

  // Configuration registers.
  logic [DELAY_BITS-1:0] delay_r;
  logic [GAIN_BITS-1:0]  gain_r;
  logic [WIDTH_BITS-1:0] width_r;
  logic [MIX_BITS-1:0]   mix_r;

  // Control state.
  state_t                 state_r, state_nxt;
  logic [STEP_BITS-1:0]   step_r, step_nxt;
  logic [PTR_BITS-1:0]    wp_r;
  logic                   wrapped_r;
  logic                   rd_valid_r;
  logic                   out_valid_r;

  // Payload registers.
  logic signed [SAMPLE_BITS-1:0] dry_l_r, dry_r_r;
  logic signed [SAMPLE_BITS-1:0] out_l_r, out_r_r;

  // Datapath signals.
  logic                          in_xfer;
  logic                          out_free;
  logic                          commit;
  logic [DW-1:0]                 d_wide;
  logic [PTR_BITS-1:0]           d_eff;
  logic [PTR_BITS:0]             rp_diff;
  logic [PTR_BITS-1:0]           rp;
  logic [GAIN_BITS-1:0]          g_eff;
  logic [FACTOR_BITS-1:0]        w_eff;
  logic [FACTOR_BITS-1:0]        m_eff;
  logic [SAMPLE_BITS-1:0]        rdata_l, rdata_r;
  logic signed [SAMPLE_BITS-1:0] wet_l, wet_r;
  logic [SAMPLE_BITS-1:0]        wdata_l, wdata_r;

  mac_ctrl_t                     ctrl_fb, ctrl_out;
  logic signed [SAMPLE_BITS:0]   mcand [4];
  logic signed [SAMPLE_BITS:0]   base  [4];
  logic [FACTOR_BITS-1:0]        mplier [4];
  logic signed [SAMPLE_BITS+1:0] result [4];

  assign in_ready  = (state_r == ST_IDLE);
  assign in_xfer   = in_valid & in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_left  = out_l_r;
  assign out_right = out_r_r;
  assign out_free  = !out_valid_r || out_ready;
  assign commit    = (state_r == ST_WRITE) && out_free;

  // Configuration transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= DELAY_RESET;
      gain_r  <= GAIN_RESET;
      width_r <= WIDTH_RESET;
      mix_r   <= MIX_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DELAY: delay_r <= cfg_data[DELAY_BITS-1:0];
        REG_GAIN:  gain_r  <= cfg_data[GAIN_BITS-1:0];
        REG_WIDTH: width_r <= cfg_data[WIDTH_BITS-1:0];
        REG_MIX:   mix_r   <= cfg_data[MIX_BITS-1:0];
        default:   ;
      endcase
    end
  end

  // Effective factors after clamping.
  always_comb begin
    g_eff = (gain_r > FB_LIMIT) ? FB_LIMIT : gain_r;
    w_eff = (width_r > UNITY) ? UNITY : width_r;
    m_eff = (mix_r > UNITY) ? UNITY : mix_r;
    d_wide = DW'(delay_r);
    if (d_wide == '0) begin
      d_eff = PTR_BITS'(1);
    end else if (d_wide > D_MAX) begin
      d_eff = P_LAST;
    end else begin
      d_eff = d_wide[PTR_BITS-1:0];
    end
  end

  // Read address behind the write pointer, wrapping at the line depth.
  always_comb begin
    rp_diff = {1'b0, wp_r} - {1'b0, d_eff};
    if (rp_diff[PTR_BITS]) begin
      rp_diff = rp_diff + (PTR_BITS+1)'(LINE_DEPTH);
    end
    rp = rp_diff[PTR_BITS-1:0];
  end

  sppd_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(LINE_DEPTH)) u_ram_left (
    .clk   (clk),
    .we    (commit),
    .waddr (wp_r),
    .wdata (wdata_l),
    .re    (in_xfer),
    .raddr (rp),
    .rdata (rdata_l)
  );

  sppd_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(LINE_DEPTH)) u_ram_right (
    .clk   (clk),
    .we    (commit),
    .waddr (wp_r),
    .wdata (wdata_r),
    .re    (in_xfer),
    .raddr (rp),
    .rdata (rdata_r)
  );

  // Entries not yet written since reset read as zero.
  assign wet_l = rd_valid_r ? $signed(rdata_l) : '0;
  assign wet_r = rd_valid_r ? $signed(rdata_r) : '0;

  // Lane inputs: lanes 0 and 1 do the cross fade and then the gain,
  // lanes 2 and 3 do the output crossfade.
  always_comb begin
    if (state_r == ST_LOAD_B) begin
      mcand[0]  = result[0][SAMPLE_BITS:0];
      base[0]   = '0;
      mplier[0] = FACTOR_BITS'(g_eff);
      mcand[1]  = result[1][SAMPLE_BITS:0];
      base[1]   = '0;
      mplier[1] = FACTOR_BITS'(g_eff);
    end else begin
      mcand[0]  = (SAMPLE_BITS+1)'(wet_r) - (SAMPLE_BITS+1)'(wet_l);
      base[0]   = (SAMPLE_BITS+1)'(wet_l);
      mplier[0] = w_eff;
      mcand[1]  = (SAMPLE_BITS+1)'(wet_l) - (SAMPLE_BITS+1)'(wet_r);
      base[1]   = (SAMPLE_BITS+1)'(wet_r);
      mplier[1] = w_eff;
    end
    mcand[2]  = (SAMPLE_BITS+1)'(wet_l) - (SAMPLE_BITS+1)'(dry_l_r);
    base[2]   = (SAMPLE_BITS+1)'(dry_l_r);
    mplier[2] = m_eff;
    mcand[3]  = (SAMPLE_BITS+1)'(wet_r) - (SAMPLE_BITS+1)'(dry_r_r);
    base[3]   = (SAMPLE_BITS+1)'(dry_r_r);
    mplier[3] = m_eff;
  end

  always_comb begin
    ctrl_fb.load  = (state_r == ST_LOAD) || (state_r == ST_LOAD_B);
    ctrl_fb.step  = (state_r == ST_MUL_A) || (state_r == ST_MUL_B);
    ctrl_out.load = (state_r == ST_LOAD);
    ctrl_out.step = (state_r == ST_MUL_A);
  end

  for (genvar i = 0; i < 4; i++) begin : g_lane
    sppd_mac #(.SAMPLE_BITS(SAMPLE_BITS)) u_mac (
      .clk    (clk),
      .ctrl   ((i < 2) ? ctrl_fb : ctrl_out),
      .mcand  (mcand[i]),
      .mplier (mplier[i]),
      .base   (base[i]),
      .result (result[i])
    );
  end

  // Values stored into the lines: dry input plus feedback, saturated.
  always_comb begin
    wdata_l = sat_sample((SAMPLE_BITS+2)'(dry_l_r) + result[0]);
    wdata_r = sat_sample((SAMPLE_BITS+2)'(dry_r_r) + result[1]);
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_nxt = ST_MUL_A;
        step_nxt  = '0;
      end
      ST_MUL_A: begin
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_BITS'(DIGIT_STEPS - 1)) begin
          state_nxt = ST_LOAD_B;
        end
      end
      ST_LOAD_B: begin
        state_nxt = ST_MUL_B;
        step_nxt  = '0;
      end
      ST_MUL_B: begin
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_BITS'(DIGIT_STEPS - 1)) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers: state, pointer, fill status and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      wp_r        <= '0;
      wrapped_r   <= 1'b0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (in_xfer) begin
        rd_valid_r <= wrapped_r || (rp < wp_r);
      end
      if (commit) begin
        if (wp_r == P_LAST) begin
          wp_r      <= '0;
          wrapped_r <= 1'b1;
        end else begin
          wp_r <= wp_r + 1'b1;
        end
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Input capture and output register.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      dry_l_r <= in_left;
      dry_r_r <= in_right;
    end
    if (commit) begin
      out_l_r <= sat_sample(result[2]);
      out_r_r <= sat_sample(result[3]);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sppd_checker.sv =====
// ----------------------------------------------------------------------------
// Stereo ping-pong delay port checker
// Watches the top-level ports for ordering and handshake slips.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stereo_ping_pong_delay_unit_macros.svh"

module sppd_checker #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic signed [SAMPLE_BITS-1:0]        in_left,
  input  logic signed [SAMPLE_BITS-1:0]        in_right,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic signed [SAMPLE_BITS-1:0]        out_left,
  input  logic signed [SAMPLE_BITS-1:0]        out_right,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic [sppd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [sppd_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  logic [1:0] pending_r;
  logic       in_xfer;
  logic       out_xfer;
  logic       unused_ports;

  assign in_xfer  = in_valid & in_ready;
  assign out_xfer = out_valid & out_ready;
  assign unused_ports = ^{in_left, in_right, cfg_valid, cfg_ready, cfg_index, cfg_data};

  // Items taken in but not yet delivered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else if (in_xfer && !out_xfer) begin
      pending_r <= pending_r + 2'd1;
    end else if (out_xfer && !in_xfer) begin
      pending_r <= pending_r - 2'd1;
    end
  end

  // A result is only shown for an item that was taken in.
  `SPPD_ASSERT_SAME(a_no_invented, clk, rst_n, out_valid, pending_r != 2'd0, "result without input")

  // At most one item in work and one waiting at the output.
  `SPPD_ASSERT_SAME(a_pending_bound, clk, rst_n, 1'b1, pending_r != 2'd3, "too many items held")

  // One item is worked at a time: the input closes after each transfer.
  `SPPD_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_xfer, !in_ready, "input open after transfer")

  // A stalled result holds its value.
  `SPPD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_left) && $stable(out_right) && (unused_ports == unused_ports), "stalled result changed")

endmodule

bind stereo_ping_pong_delay_unit sppd_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_sppd_checker (.*);

`default_nettype wire

// ===== tb/sv/stereo_ping_pong_delay_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Stereo ping-pong delay unit testbench
// Streams stereo pairs through the delay unit under several register settings
// and idle patterns. Every mixed pair returned is compared with a bit-exact
// prediction of the two delay lines, the cross feedback and the crossfade.
// ----------------------------------------------------------------------------
module stereo_ping_pong_delay_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sppd_pkg::*;

  localparam int LINE_DEPTH       = 32768;
  localparam int SAMPLE_BITS      = 16;
  localparam longint SAMPLE_MAX   = 32767;
  localparam longint SAMPLE_MIN   = -32768;
  localparam int CYCLE_LIMIT      = 1000000;
  localparam int SETTLE_CYCLES    = 60;
  localparam int PAIRS_PER_PHASE  = 156;
  localparam int RANDOM_PHASES    = 12;
  localparam int BACKLOG_PAIRS    = 60;
  localparam int HOLD_OFF_LENGTH  = 500;

  // Indexes past the register list; writes there must be ignored.
  localparam logic [CFG_INDEX_BITS-1:0] SPARE_INDEX_LO = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] SPARE_INDEX_HI = 3'd7;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
  } stereo_pair_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic signed [SAMPLE_BITS-1:0]  in_left = '0;
  logic signed [SAMPLE_BITS-1:0]  in_right = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic signed [SAMPLE_BITS-1:0]  out_left;
  logic signed [SAMPLE_BITS-1:0]  out_right;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [CFG_INDEX_BITS-1:0]      cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]       cfg_data = '0;

  // Predicted state of the block.
  shortint                        left_history [LINE_DEPTH];
  shortint                        right_history [LINE_DEPTH];
  logic [DELAY_BITS-1:0]          next_slot = '0;
  logic [DELAY_BITS-1:0]          delay_reg = DELAY_RESET;
  logic [GAIN_BITS-1:0]           gain_reg = GAIN_RESET;
  logic [WIDTH_BITS-1:0]          width_reg = WIDTH_RESET;
  logic [MIX_BITS-1:0]            mix_reg = MIX_RESET;

  stereo_pair_t                   expected_pairs [$];
  int                             error_count = 0;
  int                             cycle_count = 0;
  int                             in_idle_pct = 0;
  int                             out_stall_pct = 0;
  int                             hold_off_cycles = 0;

  stereo_ping_pong_delay_unit #(
    .LINE_DEPTH (LINE_DEPTH),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_left  (in_left),
    .in_right (in_right),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_left (out_left),
    .out_right(out_right),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Scaling by a Q1.15 factor rounds half up.
  function automatic longint q15_round(input longint v);
    return (v + 16384) >>> 15;
  endfunction

  function automatic longint crossfade(input longint a, input longint b, input longint wb);
    return q15_round(a * (32768 - wb) + b * wb);
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] clip_sample(input longint v);
    if (v > SAMPLE_MAX) return SAMPLE_MAX[SAMPLE_BITS-1:0];
    if (v < SAMPLE_MIN) return SAMPLE_MIN[SAMPLE_BITS-1:0];
    return v[SAMPLE_BITS-1:0];
  endfunction

  // One step of the echo: read both taps, store input plus cross feedback,
  // and queue the crossfaded output pair.
  function automatic void predict_echo_pair(input logic signed [SAMPLE_BITS-1:0] dry_l,
                                            input logic signed [SAMPLE_BITS-1:0] dry_r);
    logic [DELAY_BITS-1:0] lag;
    logic [DELAY_BITS-1:0] tap;
    longint                g;
    longint                w;
    longint                m;
    longint                wet_l;
    longint                wet_r;
    longint                fb_l;
    longint                fb_r;
    stereo_pair_t          want;
    lag = delay_reg;
    if (lag == 0) lag = 1;
    tap = next_slot - lag;
    g = (gain_reg > FB_LIMIT) ? longint'(FB_LIMIT) : longint'(gain_reg);
    w = (width_reg > UNITY) ? longint'(UNITY) : longint'(width_reg);
    m = (mix_reg > UNITY) ? longint'(UNITY) : longint'(mix_reg);
    wet_l = left_history[tap];
    wet_r = right_history[tap];
    fb_l = q15_round(crossfade(wet_l, wet_r, w) * g);
    fb_r = q15_round(crossfade(wet_r, wet_l, w) * g);
    left_history[next_slot] = clip_sample(longint'(dry_l) + fb_l);
    right_history[next_slot] = clip_sample(longint'(dry_r) + fb_r);
    want.left = clip_sample(crossfade(dry_l, wet_l, m));
    want.right = clip_sample(crossfade(dry_r, wet_r, m));
    next_slot = next_slot + 1'b1;
    expected_pairs.push_back(want);
  endfunction

  // Register write as the block applies it; unknown indexes change nothing.
  function automatic void apply_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                         input logic [CFG_DATA_BITS-1:0] data);
    case (idx)
      REG_DELAY: delay_reg = data[DELAY_BITS-1:0];
      REG_GAIN:  gain_reg = data[GAIN_BITS-1:0];
      REG_WIDTH: width_reg = data[WIDTH_BITS-1:0];
      REG_MIX:   mix_reg = data[MIX_BITS-1:0];
      default: ;
    endcase
  endfunction

  // Mostly full-range samples, with extremes and small values mixed in.
  function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
    case ($urandom_range(0, 9))
      0: return SAMPLE_MAX[SAMPLE_BITS-1:0];
      1: return SAMPLE_MIN[SAMPLE_BITS-1:0];
      2: return $urandom_range(0, 128) - 64;
      default: return $urandom;
    endcase
  endfunction

  // Result checker: each transfer on the output is matched with the oldest
  // prediction.
  always @(posedge clk) begin : check_result
    stereo_pair_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_pairs.size() == 0) begin
        $display("%0t: unexpected output pair left %0d right %0d",
                 $time, out_left, out_right);
        error_count++;
      end else begin
        want = expected_pairs.pop_front();
        if (out_left !== want.left) begin
          $display("%0t: out_left expected %0d actual %0d", $time, want.left, out_left);
          error_count++;
        end
        if (out_right !== want.right) begin
          $display("%0t: out_right expected %0d actual %0d", $time, want.right, out_right);
          error_count++;
        end
      end
    end
  end

  // Receiver: a counted hold-off takes priority over random stalls.
  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles = hold_off_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
    end
  end

  // Offer one stereo pair, with optional idle cycles first, and predict its
  // result once the transfer happens. Valid stays high for a following pair.
  task automatic send_pair(input logic signed [SAMPLE_BITS-1:0] l,
                           input logic signed [SAMPLE_BITS-1:0] r);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_left <= l;
    in_right <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_echo_pair(l, r);
  endtask

  // Stop offering pairs and wait until every predicted pair has come back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_pairs.size() != 0) @(posedge clk);
  endtask

  // One register write transfer; valid is left high for a following write.
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_register(idx, data);
  endtask

  // Write all four registers once the block is idle, optionally followed by
  // a write to an index past the register list.
  task automatic set_config(input logic [CFG_DATA_BITS-1:0] lag_word,
                            input logic [CFG_DATA_BITS-1:0] gain_word,
                            input logic [CFG_DATA_BITS-1:0] width_word,
                            input logic [CFG_DATA_BITS-1:0] mix_word,
                            input bit spare_write);
    wait_for_results();
    write_reg(REG_DELAY, lag_word);
    write_reg(REG_GAIN, gain_word);
    write_reg(REG_WIDTH, width_word);
    write_reg(REG_MIX, mix_word);
    if (spare_write)
      write_reg(SPARE_INDEX_LO + $urandom_range(0, SPARE_INDEX_HI - SPARE_INDEX_LO), $urandom);
    cfg_valid <= 1'b0;
  endtask

  // Mostly short delays so the feedback recirculates many times; now and then
  // a long one. Upper data bits and over-range factors are exercised too.
  task automatic random_config();
    logic [CFG_DATA_BITS-1:0] lag_word;
    logic [CFG_DATA_BITS-1:0] gain_word;
    logic [CFG_DATA_BITS-1:0] width_word;
    logic [CFG_DATA_BITS-1:0] mix_word;
    lag_word = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 40);
    lag_word[15] = $urandom_range(0, 1);
    gain_word = ($urandom_range(0, 3) == 0) ? $urandom_range(28000, 32767)
                                            : $urandom_range(0, 32767);
    gain_word[15] = $urandom_range(0, 1);
    width_word = ($urandom_range(0, 3) == 0) ? $urandom_range(32768, 65535)
                                             : $urandom_range(0, 32768);
    mix_word = ($urandom_range(0, 3) == 0) ? $urandom_range(32768, 65535)
                                           : $urandom_range(0, 32768);
    set_config(lag_word, gain_word, width_word, mix_word, $urandom_range(0, 3) == 0);
  endtask

  // Register defaults after reset, with the sample extremes at the inputs.
  task automatic test_reset_defaults();
    in_idle_pct = 0;
    out_stall_pct = 0;
    send_pair(SAMPLE_MAX[15:0], SAMPLE_MIN[15:0]);
    send_pair(SAMPLE_MIN[15:0], SAMPLE_MAX[15:0]);
    send_pair(16'sd0, 16'sd0);
    send_pair(-16'sd1, 16'sd1);
    send_pair(16'sd16384, -16'sd16384);
    send_pair(SAMPLE_MAX[15:0], SAMPLE_MAX[15:0]);
  endtask

  // Clamping of every register, masking of upper data bits, the longest
  // delay, and writes to unknown indexes.
  task automatic test_register_limits();
    // A zero delay acts as one; gain, width and mix over range are clamped,
    // so feedback at its limit drives the stored sum into saturation.
    set_config(16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    send_pair(SAMPLE_MAX[15:0], SAMPLE_MAX[15:0]);
    send_pair(SAMPLE_MAX[15:0], SAMPLE_MAX[15:0]);
    send_pair(SAMPLE_MAX[15:0], SAMPLE_MIN[15:0]);
    send_pair(SAMPLE_MIN[15:0], SAMPLE_MIN[15:0]);
    send_pair(SAMPLE_MIN[15:0], SAMPLE_MIN[15:0]);
    // Longest delay with no feedback and a fully dry output.
    set_config(16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_pair(16'sd1234, -16'sd4321);
    send_pair(SAMPLE_MIN[15:0], SAMPLE_MAX[15:0]);
    send_pair(-16'sd1, -16'sd1);
    // Exact limits, followed by a write that must be ignored.
    set_config(16'h0001, {1'b0, FB_LIMIT}, UNITY, UNITY, 1'b1);
    send_pair(SAMPLE_MAX[15:0], 16'sd0);
    send_pair(16'sd0, SAMPLE_MIN[15:0]);
    send_pair(16'sd5000, 16'sd7000);
  endtask

  // Random pairs under random settings, cycling through the idle patterns.
  task automatic test_random_traffic();
    int in_pct [4];
    int out_pct [4];
    in_pct = '{0, 87, 0, 19};
    out_pct = '{0, 0, 87, 19};
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      random_config();
      in_idle_pct = in_pct[p % 4];
      out_stall_pct = out_pct[p % 4];
      for (int i = 0; i < PAIRS_PER_PHASE; i++)
        send_pair(random_sample(), random_sample());
    end
  endtask

  // The receiver holds off for a long stretch while pairs keep coming, so
  // the block fills up and stops taking input.
  task automatic test_output_backpressure();
    random_config();
    in_idle_pct = 0;
    out_stall_pct = 0;
    hold_off_cycles = HOLD_OFF_LENGTH;
    for (int i = 0; i < BACKLOG_PAIRS; i++)
      send_pair(random_sample(), random_sample());
  endtask

  initial begin
    for (int i = 0; i < LINE_DEPTH; i++) begin
      left_history[i] = 0;
      right_history[i] = 0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_register_limits();
    test_random_traffic();
    test_output_backpressure();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_pairs.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
